[rtl/ffha_pkg.sv]
// package for the first-fit heap allocator
// holds default sizes, field widths, opcodes and the control state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int unsigned DEF_HEAP_BYTES   = 32768;
  localparam int unsigned DEF_HEADER_BYTES = 24;

  localparam int unsigned REQ_W  = 16;
  localparam int unsigned ADDR_W = 15;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_CHK,
    ST_A_WR,
    ST_F_CHK,
    ST_M_START,
    ST_M_LOAD,
    ST_M_CHK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/ffha_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator. Block headers ({free, payload size}) live in one
// header ram indexed by byte offset; every request but a null free or a
// zero-size allocate walks the block chain from offset 0, one header per
// cycle through the ram's single read port. An allocate stops at the first
// free block that fits and writes its header, the tail header first when
// the block is split. A free walks to find the block, marks it free, then
// makes a coalescing pass from offset 0 that reads each header in turn. A
// null free or zero-size allocate goes straight to done. A stalled output
// holds the finished request until the output register frees up. After
// reset the block writes the initial free header before it takes its first
// transfer. Exactly one result follows every input transfer; the output
// register lets the next input be taken while a result waits.
// depends on ffha_pkg and ffha_ram
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              opcode,
  input  wire logic [REQ_W-1:0]  request_size,
  input  wire logic [ADDR_W-1:0] block_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   granted,
  output logic      [ADDR_W-1:0] payload_address
);

  localparam int unsigned OFF_W = $clog2(HEAP_BYTES);
  localparam int unsigned POS_W = OFF_W + 1;
  localparam int unsigned SZ_W  = OFF_W;
  localparam int unsigned ENT_W = SZ_W + 1;
  localparam int unsigned CW    = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 1;

  localparam logic [POS_W-1:0] HEAP_P  = POS_W'(HEAP_BYTES);
  localparam logic [POS_W-1:0] HDR_P   = POS_W'(HEADER_BYTES);
  localparam logic [CW-1:0]    HDR_C   = CW'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]  INIT_SZ = SZ_W'(HEAP_BYTES - HEADER_BYTES);

  state_t state, state_next;

  // request and walk registers
  logic [REQ_W-1:0]  req, req_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [OFF_W-1:0]  off, off_next;
  logic [POS_W-1:0]  nxt, nxt_next;
  logic              cur_free, cur_free_next;
  logic [SZ_W-1:0]   cur_size, cur_size_next;
  logic              res_grant, res_grant_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;

  // header ram
  logic             ram_we;
  logic [OFF_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [OFF_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  ffha_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HEAP_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic              hdr_free;
  logic [SZ_W-1:0]   hdr_size;
  logic [POS_W-1:0]  walk_next;
  logic              walk_end;
  logic              fits;
  logic              split;
  logic [OFF_W-1:0]  tail_off;
  logic [SZ_W-1:0]   tail_size;
  logic              match;
  logic [ADDR_W-1:0] grant_addr;
  logic [SZ_W-1:0]   merged_size;
  logic [POS_W-1:0]  m_next;
  logic              m_end;
  logic              do_merge;
  logic              in_xfer;
  logic              out_free;

  assign hdr_free   = ram_rdata[SZ_W];
  assign hdr_size   = ram_rdata[SZ_W-1:0];
  assign walk_next  = POS_W'(off) + HDR_P + POS_W'(hdr_size);
  assign walk_end   = (walk_next >= HEAP_P);
  assign fits       = hdr_free && (CW'(hdr_size) >= CW'(req));
  assign split      = CW'(hdr_size) > (CW'(req) + HDR_C);
  assign tail_off   = OFF_W'(CW'(off) + HDR_C + CW'(req));
  assign tail_size  = SZ_W'(CW'(hdr_size) - CW'(req) - HDR_C);
  assign match      = (CW'(off) + HDR_C) == CW'(addr);
  assign grant_addr = ADDR_W'(CW'(off) + HDR_C);
  assign merged_size = SZ_W'(POS_W'(cur_size) + POS_W'(hdr_size) + HDR_P);
  // next header after nxt, same whether nxt is absorbed or becomes current
  assign m_next     = nxt + HDR_P + POS_W'(hdr_size);
  assign m_end      = (m_next >= HEAP_P);
  assign do_merge   = cur_free && hdr_free;
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    addr      <= addr_next;
    off       <= off_next;
    nxt       <= nxt_next;
    cur_free  <= cur_free_next;
    cur_size  <= cur_size_next;
    res_grant <= res_grant_next;
    res_addr  <= res_addr_next;
    if (state == ST_DONE && out_free) begin
      granted         <= res_grant;
      payload_address <= res_addr;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_ALLOC) begin
            state_next = (request_size == '0) ? ST_DONE : ST_A_CHK;
          end else begin
            state_next = (block_address == '0) ? ST_DONE : ST_F_CHK;
          end
        end
      end
      ST_A_CHK: begin
        if (fits) begin
          state_next = split ? ST_A_WR : ST_DONE;
        end else if (walk_end) begin
          state_next = ST_DONE;
        end
      end
      ST_A_WR: state_next = ST_DONE;
      ST_F_CHK: begin
        if (match || walk_end) begin
          state_next = ST_M_START;
        end
      end
      ST_M_START: state_next = ST_M_LOAD;
      ST_M_LOAD:  state_next = walk_end ? ST_DONE : ST_M_CHK;
      ST_M_CHK: begin
        if (m_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // datapath and ram control
  always_comb begin
    req_next       = req;
    addr_next      = addr;
    off_next       = off;
    nxt_next       = nxt;
    cur_free_next  = cur_free;
    cur_size_next  = cur_size;
    res_grant_next = res_grant;
    res_addr_next  = res_addr;
    ram_we         = 1'b0;
    ram_waddr      = off;
    ram_wdata      = {1'b0, hdr_size};
    ram_raddr      = off;
    unique case (state)
      ST_INIT: begin
        // heap starts as one free block
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, INIT_SZ};
      end
      ST_IDLE: begin
        ram_raddr = '0;
        if (in_xfer) begin
          req_next       = request_size;
          addr_next      = block_address;
          off_next       = '0;
          res_grant_next = 1'b0;
          res_addr_next  = '0;
        end
      end
      ST_A_CHK: begin
        if (fits) begin
          res_grant_next = 1'b1;
          res_addr_next  = grant_addr;
          ram_we         = 1'b1;
          if (split) begin
            // tail header first, own header next cycle
            ram_waddr = tail_off;
            ram_wdata = {1'b1, tail_size};
          end else begin
            ram_wdata = {1'b0, hdr_size};
          end
        end else begin
          off_next  = walk_next[OFF_W-1:0];
          ram_raddr = walk_next[OFF_W-1:0];
        end
      end
      ST_A_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, SZ_W'(req)};
      end
      ST_F_CHK: begin
        if (match) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, hdr_size};
        end else begin
          off_next  = walk_next[OFF_W-1:0];
          ram_raddr = walk_next[OFF_W-1:0];
        end
      end
      ST_M_START: begin
        off_next  = '0;
        ram_raddr = '0;
      end
      ST_M_LOAD: begin
        cur_free_next = hdr_free;
        cur_size_next = hdr_size;
        nxt_next      = walk_next;
        ram_raddr     = walk_next[OFF_W-1:0];
      end
      ST_M_CHK: begin
        nxt_next  = m_next;
        ram_raddr = m_next[OFF_W-1:0];
        if (do_merge) begin
          cur_size_next = merged_size;
          ram_we        = 1'b1;
          ram_wdata     = {1'b1, merged_size};
        end else begin
          off_next      = nxt[OFF_W-1:0];
          cur_free_next = hdr_free;
          cur_size_next = hdr_size;
        end
      end
      ST_DONE: begin
        ram_raddr = off;
      end
      default: begin
        ram_raddr = off;
      end
    endcase
  end

endmodule

`default_nettype wire
